// ===== sv/raw_screen_image_to_bgr_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the raw screen image converter
// Shared property forms used by the concurrent checks of the top level.
// ---------------------------------------------------------------------------
`ifndef RAW_SCREEN_IMAGE_TO_BGR_ASSERT_SVH
`define RAW_SCREEN_IMAGE_TO_BGR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSIB_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSIB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rsib_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsib_pkg
// Constants, status codes and the parser result type of the converter.
// ---------------------------------------------------------------------------
package rsib_pkg;

    // Largest accepted image width or height.
    localparam int MAX_DIMENSION = 4096;

    // Saturated sizes hold up to MAX_DIMENSION + 1.
    localparam int DIM_W = $clog2(MAX_DIMENSION + 2);
    // Column and row counters hold up to MAX_DIMENSION.
    localparam int CNT_W = $clog2(MAX_DIMENSION + 1);

    // Header layout.
    localparam logic [3:0] HDR_BYTES = 4'd12;
    localparam logic [31:0] FMT_RGBA8888 = 32'd1;
    localparam logic [31:0] FMT_RGB565 = 32'd4;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t ST_PIXEL = 2'd0;
    localparam status_t ST_BAD_FORMAT = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_TOO_LARGE = 2'd3;

    // One result as it leaves the parser, before color expansion.
    // For RGB565 the raw pixel sits in pix[15:0]; for RGBA8888 pix holds
    // red, green and blue from the lowest byte up.
    typedef struct packed {
        status_t     status;
        logic        last;
        logic        is565;
        logic [23:0] pix;
    } res_t;

endpackage

// ===== sv/rsib_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsib_parser
// Header decoding, pixel byte assembly and image position tracking.
// ---------------------------------------------------------------------------
module rsib_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                frame_start,
    output logic                res_valid,
    output rsib_pkg::res_t      res,
    output logic                active
);

    localparam logic [3:0] IDX_WIDTH = 4'd4;
    localparam logic [3:0] IDX_HEIGHT = 4'd8;

    logic [3:0]                 hdr_idx_reg, hdr_idx_next;
    logic [31:0]                hdr_word_reg, hdr_word_next;
    logic [rsib_pkg::DIM_W-1:0] width_reg, width_next;
    logic [rsib_pkg::DIM_W-1:0] height_reg, height_next;
    logic                       is565_reg, is565_next;
    logic [1:0]                 phase_reg, phase_next;
    logic [23:0]                partial_reg, partial_next;
    logic [rsib_pkg::CNT_W-1:0] col_reg, col_next;
    logic [rsib_pkg::CNT_W-1:0] row_reg, row_next;
    logic                       active_reg, active_next;

    logic                       pix_done;
    logic [23:0]                pix;
    logic [rsib_pkg::DIM_W-1:0] col_p1;
    logic [rsib_pkg::DIM_W-1:0] row_p1;
    logic                       last;

    // Saturate a header word to the size range.
    function automatic logic [rsib_pkg::DIM_W-1:0] clamp_size(input logic [31:0] v);
        if (v > 32'(rsib_pkg::MAX_DIMENSION)) begin
            return rsib_pkg::DIM_W'(rsib_pkg::MAX_DIMENSION + 1);
        end
        return v[rsib_pkg::DIM_W-1:0];
    endfunction

    // Next-state and result logic for one consumed byte.
    always_comb
    begin
        hdr_idx_next = hdr_idx_reg;
        hdr_word_next = hdr_word_reg;
        width_next = width_reg;
        height_next = height_reg;
        is565_next = is565_reg;
        phase_next = phase_reg;
        partial_next = partial_reg;
        col_next = col_reg;
        row_next = row_reg;
        active_next = active_reg;
        res_valid = 1'b0;
        res = '0;
        pix_done = 1'b0;
        pix = '0;

        if (step) begin
            // A frame start abandons whatever was in progress.
            if (frame_start) begin
                active_next = 1'b1;
                hdr_idx_next = '0;
                phase_next = '0;
                partial_next = '0;
                col_next = '0;
                row_next = '0;
            end

            if (active_next) begin
                if (hdr_idx_next < rsib_pkg::HDR_BYTES) begin
                    // Header bytes shift into a little-endian word.
                    hdr_word_next = {data_byte, hdr_word_reg[31:8]};
                    hdr_idx_next = hdr_idx_next + 4'd1;
                    case (hdr_idx_next)
                        IDX_WIDTH:  width_next = clamp_size(hdr_word_next);
                        IDX_HEIGHT: height_next = clamp_size(hdr_word_next);
                        rsib_pkg::HDR_BYTES:
                        begin
                            res.status = rsib_pkg::ST_PIXEL;
                            if (hdr_word_next == rsib_pkg::FMT_RGB565) begin
                                is565_next = 1'b1;
                            end else if (hdr_word_next == rsib_pkg::FMT_RGBA8888) begin
                                is565_next = 1'b0;
                            end else begin
                                res.status = rsib_pkg::ST_BAD_FORMAT;
                            end
                            if (res.status == rsib_pkg::ST_PIXEL) begin
                                if (width_reg == '0 || height_reg == '0) begin
                                    res.status = rsib_pkg::ST_EMPTY;
                                end else if (width_reg > rsib_pkg::DIM_W'(rsib_pkg::MAX_DIMENSION)
                                    || height_reg > rsib_pkg::DIM_W'(rsib_pkg::MAX_DIMENSION))
                                begin
                                    res.status = rsib_pkg::ST_TOO_LARGE;
                                end
                            end
                            if (res.status != rsib_pkg::ST_PIXEL) begin
                                active_next = 1'b0;
                                res_valid = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end else if (is565_reg) begin
                    // RGB565: low byte first, then high byte completes the pixel.
                    if (phase_next == 2'd0) begin
                        partial_next = {16'd0, data_byte};
                        phase_next = 2'd1;
                    end else begin
                        pix_done = 1'b1;
                        pix = {8'd0, data_byte, partial_next[7:0]};
                        phase_next = '0;
                        partial_next = '0;
                    end
                end else begin
                    // RGBA8888: three color bytes collect, alpha completes the pixel.
                    if (phase_next != 2'd3) begin
                        partial_next = partial_next | ({16'd0, data_byte} << {phase_next, 3'b000});
                        phase_next = phase_next + 2'd1;
                    end else begin
                        pix_done = 1'b1;
                        pix = partial_next;
                        phase_next = '0;
                        partial_next = '0;
                    end
                end
            end
        end

        // Position tracking and the last-pixel mark.
        col_p1 = rsib_pkg::DIM_W'(col_next) + rsib_pkg::DIM_W'(1);
        row_p1 = rsib_pkg::DIM_W'(row_next) + rsib_pkg::DIM_W'(1);
        last = (col_p1 == width_reg) && (row_p1 == height_reg);
        if (pix_done) begin
            if (col_p1 >= width_reg) begin
                col_next = '0;
                row_next = row_p1[rsib_pkg::CNT_W-1:0];
            end else begin
                col_next = col_p1[rsib_pkg::CNT_W-1:0];
            end
            if (last) begin
                active_next = 1'b0;
            end
            res_valid = 1'b1;
            res.status = rsib_pkg::ST_PIXEL;
            res.last = last;
            res.is565 = is565_reg;
            res.pix = pix;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hdr_idx_reg <= '0;
            hdr_word_reg <= '0;
            width_reg <= '0;
            height_reg <= '0;
            is565_reg <= 1'b0;
            phase_reg <= '0;
            partial_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            active_reg <= 1'b0;
        end else begin
            hdr_idx_reg <= hdr_idx_next;
            hdr_word_reg <= hdr_word_next;
            width_reg <= width_next;
            height_reg <= height_next;
            is565_reg <= is565_next;
            phase_reg <= phase_next;
            partial_reg <= partial_next;
            col_reg <= col_next;
            row_reg <= row_next;
            active_reg <= active_next;
        end
    end

    assign active = active_reg;

endmodule

// ===== sv/rsib_convert.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsib_convert
// Expands a parsed pixel to 8-bit blue, green and red components.
// ---------------------------------------------------------------------------
module rsib_convert (
    input  rsib_pkg::res_t      res,
    output logic [7:0]          blue,
    output logic [7:0]          green,
    output logic [7:0]          red
);

    // Five-bit field to eight bits, rounded: (v * 527 + 23) >> 6.
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [13:0] prod;
        prod = {9'd0, v} * 14'd527 + 14'd23;
        return prod[13:6];
    endfunction

    // Six-bit field to eight bits, rounded: (v * 259 + 33) >> 6.
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [13:0] prod;
        prod = {8'd0, v} * 14'd259 + 14'd33;
        return prod[13:6];
    endfunction

    // Select between RGB565 expansion and RGBA8888 pass-through.
    always_comb
    begin
        if (res.is565) begin
            red = expand5(res.pix[15:11]);
            green = expand6(res.pix[10:5]);
            blue = expand5(res.pix[4:0]);
        end else begin
            red = res.pix[7:0];
            green = res.pix[15:8];
            blue = res.pix[23:16];
        end
    end

endmodule

// ===== sv/raw_screen_image_to_bgr.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// raw_screen_image_to_bgr
// Converts a raw screen capture byte stream to BGR pixels.
// ---------------------------------------------------------------------------
// Usage:
//   The input stream carries one capture byte per item in s_tdata; s_tuser
//   marks the first header byte of a new image. Twelve header bytes give
//   width, height and format as little-endian words; pixel bytes follow.
//   The output stream carries one BGR pixel per item, with m_tlast on the
//   final pixel and m_tuser holding the status (pixel or a header error).
//   A header error gives a single item with zero color and ends the frame.
//   Each accepted byte waits in the input register until the result register
//   is free; it is then parsed, and any result it gives is loaded into the
//   result register and m_tvalid rises.
//   Throughput: one byte per cycle while the receiver does not stall; a pixel
//   takes two bytes (RGB565) or four bytes (RGBA8888).
//   Reset clears all control state; the block then ignores bytes until a
//   byte with the start flag arrives.
//   When the receiver stalls, the result register holds and the input
//   register, if empty, still takes one more byte before s_tready falls.
// ---------------------------------------------------------------------------
`include "raw_screen_image_to_bgr_assert.svh"

module raw_screen_image_to_bgr (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] blue, [15:8] green, [23:16] red
    output logic [1:0]  m_tuser,    // [1:0] status
    output logic        m_tlast
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_start_reg;
    logic               out_ready;
    logic               step;
    logic               res_valid;
    rsib_pkg::res_t     res;
    logic               parser_active;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic               out_valid_reg;
    logic [23:0]        out_data_reg;
    logic [1:0]         out_status_reg;
    logic               out_last_reg;

    // Handshake: the result register frees up when empty or taken.
    assign out_ready = !out_valid_reg || m_tready;
    assign step = in_valid_reg && out_ready;
    assign s_tready = !in_valid_reg || out_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // Header and pixel parsing.
    rsib_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (in_byte_reg),
        .frame_start (in_start_reg),
        .res_valid   (res_valid),
        .res         (res),
        .active      (parser_active)
    );

    // Color expansion.
    rsib_convert u_convert (
        .res   (res),
        .blue  (blue),
        .green (green),
        .red   (red)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid) begin
            if (res.status == rsib_pkg::ST_PIXEL) begin
                out_data_reg <= {red, green, blue};
            end else begin
                out_data_reg <= '0;
            end
            out_status_reg <= res.status;
            out_last_reg <= res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_status_reg;
    assign m_tlast = out_last_reg;

    // Checks.
    `RSIB_ASSERT_SAME(a_err_zero, clk, rst_n, m_tvalid && m_tuser != rsib_pkg::ST_PIXEL,
        m_tdata == '0 && !m_tlast, "error result carries color or last mark")
    `RSIB_ASSERT_NEXT(a_err_idle, clk, rst_n, step && res_valid && res.status != rsib_pkg::ST_PIXEL,
        !parser_active, "frame still active after a header error")
    `RSIB_ASSERT_NEXT(a_last_idle, clk, rst_n, step && res_valid && res.last,
        !parser_active, "frame still active after its last pixel")

endmodule

// ===== sim/bgr_stream_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgr_stream_checker
// Watches both streams of the capture converter, predicts every BGR item
// from the accepted capture bytes and compares it with what comes out.
// ---------------------------------------------------------------------------
module bgr_stream_checker
    import rsib_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] frame_start
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [7:0] blue, [15:8] green, [23:16] red
    input  logic [1:0]  m_tuser,    // [1:0] status
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          pending_count
);

    // One output item in the order it is compared.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        status_t    status;
        logic       last;
    } bgr_item_t;

    bgr_item_t   expected_pixels[$];
    bgr_item_t   got_item;
    bgr_item_t   want_item;

    // Shadow copy of the converter state.
    logic [3:0]  hdr_count;
    logic [31:0] hdr_shift;
    int          img_w;
    int          img_h;
    logic        fmt565;
    int          byte_pos;
    logic [23:0] pix_bytes;
    int          col_pos;
    int          row_pos;
    logic        frame_on;

    // Sizes above the bound saturate one past it.
    function automatic int clamp_dim(input logic [31:0] v);
        return (v > MAX_DIMENSION) ? MAX_DIMENSION + 1 : int'(v);
    endfunction

    // Advance the shadow state by one capture byte and queue any result.
    task automatic convert_capture_byte(input logic [7:0] data, input logic start);
        bgr_item_t   res;
        logic        emit;
        logic        pixel_done;
        logic [15:0] px;
        status_t     err;
        emit = 1'b0;
        pixel_done = 1'b0;
        res = '0;
        if (start)
        begin
            frame_on = 1'b1;
            hdr_count = '0;
            byte_pos = 0;
            pix_bytes = '0;
            col_pos = 0;
            row_pos = 0;
        end
        if (frame_on)
        begin
            if (hdr_count < HDR_BYTES)
            begin
                // Header words arrive least significant byte first.
                hdr_shift = {data, hdr_shift[31:8]};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count == 4'd4)
                    img_w = clamp_dim(hdr_shift);
                else if (hdr_count == 4'd8)
                    img_h = clamp_dim(hdr_shift);
                else if (hdr_count == HDR_BYTES)
                begin
                    // Format first, then empty size, then oversize.
                    err = ST_PIXEL;
                    if (hdr_shift == FMT_RGB565)
                        fmt565 = 1'b1;
                    else if (hdr_shift == FMT_RGBA8888)
                        fmt565 = 1'b0;
                    else
                        err = ST_BAD_FORMAT;
                    if (err == ST_PIXEL)
                    begin
                        if (img_w == 0 || img_h == 0)
                            err = ST_EMPTY;
                        else if (img_w > MAX_DIMENSION || img_h > MAX_DIMENSION)
                            err = ST_TOO_LARGE;
                    end
                    if (err != ST_PIXEL)
                    begin
                        frame_on = 1'b0;
                        res.status = err;
                        emit = 1'b1;
                    end
                end
            end
            else if (fmt565)
            begin
                if (byte_pos == 0)
                begin
                    pix_bytes = {16'h0000, data};
                    byte_pos = 1;
                end
                else
                begin
                    // Expand 5 and 6 bit fields with rounding.
                    px = {data, pix_bytes[7:0]};
                    byte_pos = 0;
                    pix_bytes = '0;
                    res.red   = 8'((int'(px[15:11]) * 527 + 23) >> 6);
                    res.green = 8'((int'(px[10:5]) * 259 + 33) >> 6);
                    res.blue  = 8'((int'(px[4:0]) * 527 + 23) >> 6);
                    pixel_done = 1'b1;
                end
            end
            else
            begin
                if (byte_pos < 3)
                begin
                    pix_bytes = pix_bytes | (24'(data) << (8 * byte_pos));
                    byte_pos = byte_pos + 1;
                end
                else
                begin
                    // The fourth byte is alpha and is dropped.
                    res.red   = pix_bytes[7:0];
                    res.green = pix_bytes[15:8];
                    res.blue  = pix_bytes[23:16];
                    byte_pos = 0;
                    pix_bytes = '0;
                    pixel_done = 1'b1;
                end
            end
            if (pixel_done)
            begin
                // Row-major position tracking and the end-of-image mark.
                res.status = ST_PIXEL;
                res.last = (col_pos + 1 == img_w) && (row_pos + 1 == img_h);
                if (col_pos + 1 >= img_w)
                begin
                    col_pos = 0;
                    row_pos = row_pos + 1;
                end
                else
                    col_pos = col_pos + 1;
                if (res.last)
                    frame_on = 1'b0;
                emit = 1'b1;
            end
        end
        if (emit)
            expected_pixels.push_back(res);
    endtask

    // Results are checked before the same edge's byte is predicted, since a
    // byte can never produce its result at the edge that accepts it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_count = '0;
            hdr_shift = '0;
            img_w = 0;
            img_h = 0;
            fmt565 = 1'b0;
            byte_pos = 0;
            pix_bytes = '0;
            col_pos = 0;
            row_pos = 0;
            frame_on = 1'b0;
            expected_pixels.delete();
            mismatch_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_item = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser, m_tlast};
                if (expected_pixels.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected item: b=%0d g=%0d r=%0d status=%0d last=%0d",
                                 got_item.blue, got_item.green, got_item.red,
                                 got_item.status, got_item.last);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want_item = expected_pixels.pop_front();
                    if (got_item !== want_item)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("mismatch: expected b=%0d g=%0d r=%0d status=%0d last=%0d",
                                     want_item.blue, want_item.green, want_item.red,
                                     want_item.status, want_item.last);
                            $display("          got      b=%0d g=%0d r=%0d status=%0d last=%0d",
                                     got_item.blue, got_item.green, got_item.red,
                                     got_item.status, got_item.last);
                        end
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                convert_capture_byte(s_tdata, s_tuser);
            pending_count = expected_pixels.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives raw capture frames into the converter with random gaps and output
// stalls: short directed frames, then random well-formed, broken, erroneous
// and noise frames. A checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module tb;
    import rsib_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int TARGET_ITEMS = 1900;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tuser = 1'b0;    // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [7:0] blue, [15:8] green, [23:16] red
    logic [1:0]  m_tuser;           // [1:0] status
    logic        m_tlast;

    int          mismatch_count;
    int          pending_count;
    int          sent_items = 0;
    logic        tx_burst = 1'b0;
    logic        rx_burst = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    raw_screen_image_to_bgr u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    bgr_stream_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Send one capture byte; called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] data, input logic start);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = data;
        s_tuser = start;
        do
            @(posedge clk);
        while (!s_tready);
        sent_items += 1;
        @(negedge clk);
    endtask

    // Little-endian 32-bit header word.
    task automatic send_word(input logic [31:0] w, input logic start);
        for (int i = 0; i < 4; i++)
            send_byte(w[8 * i +: 8], start && (i == 0));
    endtask

    task automatic send_header(input logic [31:0] w, input logic [31:0] h,
                               input logic [31:0] fmt);
        send_word(w, 1'b1);
        send_word(h, 1'b0);
        send_word(fmt, 1'b0);
    endtask

    task automatic send_random_bytes(input int count);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Hold the sender off until every predicted item has come out.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Oversize word: just past the bound, the top of the range, or random.
    function automatic logic [31:0] oversize_word();
        case ($urandom_range(0, 3))
            0: return MAX_DIMENSION + 1;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(MAX_DIMENSION + 1, 65535);
            default: return $urandom | 32'h0001_0000;
        endcase
    endfunction

    // One random frame of a randomly chosen kind.
    task automatic run_random_frame();
        int          kind;
        int          w;
        int          h;
        int          bpp;
        logic [31:0] fmt;
        logic [31:0] ww;
        logic [31:0] hw;
        kind = $urandom_range(0, 99);
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        fmt = $urandom_range(0, 1) ? FMT_RGB565 : FMT_RGBA8888;
        bpp = (fmt == FMT_RGB565) ? 2 : 4;
        if ($urandom_range(0, 15) == 0)
        begin
            w = $urandom_range(5, 64);
            h = $urandom_range(1, 2);
        end
        else
        begin
            w = $urandom_range(1, 4);
            h = $urandom_range(1, 4);
        end
        if (kind < 70)
        begin
            // Well-formed frame, maybe followed by ignored trailing bytes.
            send_header(w, h, fmt);
            send_random_bytes(w * h * bpp);
            repeat ($urandom_range(0, 2))
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (kind < 80)
        begin
            // Frame cut short by the next start, sometimes at the largest size.
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 1))
                    w = MAX_DIMENSION;
                else
                    h = MAX_DIMENSION;
            end
            send_header(w, h, fmt);
            send_random_bytes($urandom_range(0, 3 * bpp));
        end
        else if (kind < 92)
        begin
            // Header errors of every kind, with ignored bytes after them.
            ww = w;
            hw = h;
            case ($urandom_range(0, 2))
                0:
                begin
                    fmt = $urandom;
                    if (fmt == FMT_RGB565 || fmt == FMT_RGBA8888)
                        fmt = 32'h0;
                    if ($urandom_range(0, 2) == 0)
                        ww = 0;
                    if ($urandom_range(0, 2) == 0)
                        hw = oversize_word();
                end
                1:
                begin
                    if ($urandom_range(0, 1))
                        ww = 0;
                    else
                        hw = 0;
                    if ($urandom_range(0, 1))
                        ww = (ww == 0) ? 0 : oversize_word();
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                        ww = oversize_word();
                    else
                        hw = oversize_word();
                end
            endcase
            send_header(ww, hw, fmt);
            repeat ($urandom_range(0, 4))
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            // Noise, including stray starts that leave a partial header.
            repeat ($urandom_range(1, 8))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
    endtask

    // Receiver: a random stall before each item, none in burst stretches.
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = rx_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Watchdog on cycles in which neither stream moves an item.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        do
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        while (idle_cycles < IDLE_LIMIT);
        $display("tb failed");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Bytes before any start are ignored.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);

        // RGB565 white, then a trailing byte after the last pixel.
        send_header(1, 1, FMT_RGB565);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);

        // RGB565 black and magenta on one row.
        send_header(2, 1, FMT_RGB565);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'hF8, 1'b0);

        // RGBA8888 extremes, alpha dropped.
        send_header(1, 2, FMT_RGBA8888);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);

        // Header errors: format wins over size, empty before oversize.
        send_header(0, 0, 32'h2);
        send_header(0, MAX_DIMENSION + 1, FMT_RGBA8888);
        send_header(MAX_DIMENSION, MAX_DIMENSION + 1, FMT_RGB565);

        // Restart in the middle of a header and in the middle of a pixel.
        send_word(3, 1'b1);
        send_byte(8'h02, 1'b0);
        send_header(MAX_DIMENSION, MAX_DIMENSION, FMT_RGB565);
        send_byte(8'h34, 1'b0);
        send_header(1, 1, FMT_RGB565);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);

        wait_drained();

        // Random frames until the item budget is spent.
        while (sent_items < TARGET_ITEMS)
        begin
            run_random_frame();
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;

        // Drain, then let the pipeline settle.
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
